// File: rtl/hce_pkg.sv
// Shared types, byte constants and the byte classifier for the chunk-extension checker.
package hce_pkg;

    // Parser phases, one per position in the chunk-extension grammar.
    typedef enum logic [3:0] {
        PH_EXPECT  = 4'd0,
        PH_NAME0   = 4'd1,
        PH_NAME    = 4'd2,
        PH_AFTNAME = 4'd3,
        PH_VAL0    = 4'd4,
        PH_TOKVAL  = 4'd5,
        PH_QUOTED  = 4'd6,
        PH_ESCAPE  = 4'd7,
        PH_CR      = 4'd8,
        PH_DONE    = 4'd9,
        PH_ERROR   = 4'd10
    } phase_t;

    // Status codes reported for every byte.
    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // Byte constants used by the grammar.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Classes of one byte as seen by the next-phase logic.
    typedef struct packed {
        logic ows;
        logic tchar;
        logic semi;
        logic equal;
        logic dquote;
        logic bslash;
        logic cr;
        logic lf;
        logic bad_qchar;
    } byte_class_t;

    // Sorts one byte into the classes above.
    function automatic byte_class_t classify(input logic [7:0] c);
        byte_class_t bc;
        logic        punct;
        punct = 1'b0;
        case (c) inside
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: punct = 1'b1;
            default: punct = 1'b0;
        endcase
        bc.ows       = (c == CH_SP) || (c == CH_TAB);
        bc.tchar     = ((c >= 8'h30) && (c <= 8'h39)) ||
                       ((c >= 8'h41) && (c <= 8'h5A)) ||
                       ((c >= 8'h61) && (c <= 8'h7A)) || punct;
        bc.semi      = (c == CH_SEMI);
        bc.equal     = (c == CH_EQUAL);
        bc.dquote    = (c == CH_DQUOTE);
        bc.bslash    = (c == CH_BSLASH);
        bc.cr        = (c == CH_CR);
        bc.lf        = (c == CH_LF);
        bc.bad_qchar = ((c < CH_SP) && (c != CH_TAB)) || (c == CH_DEL);
        return bc;
    endfunction

endpackage

// File: rtl/hce_in_stage.sv
// Input register stage that holds one byte transfer until the parser takes it.
module hce_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       start_line,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_start
);
    import hce_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       load;

    // The stage is full only when its byte is not moving on this cycle.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= data_byte;
            start_reg <= start_line;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_start = start_reg;

endmodule

// File: rtl/hce_phase_core.sv
// Parser phase register and the next-phase logic for one byte.
module hce_phase_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       cur_byte,
    input  logic             cur_start,
    output hce_pkg::status_t status_next
);
    import hce_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_cur;
    byte_class_t bc;

    // A new line restarts the grammar before the byte is looked at.
    assign phase_cur = cur_start ? PH_EXPECT : phase_reg;
    assign bc        = classify(cur_byte);

    // Next-phase decoder.
    always_comb
    begin
        phase_next = PH_ERROR;
        unique case (phase_cur)
            PH_EXPECT:
            begin
                if (bc.ows)       phase_next = PH_EXPECT;
                else if (bc.semi) phase_next = PH_NAME0;
                else if (bc.cr)   phase_next = PH_CR;
            end
            PH_NAME0:
            begin
                if (bc.ows)        phase_next = PH_NAME0;
                else if (bc.tchar) phase_next = PH_NAME;
            end
            PH_NAME:
            begin
                if (bc.tchar)      phase_next = PH_NAME;
                else if (bc.ows)   phase_next = PH_AFTNAME;
                else if (bc.equal) phase_next = PH_VAL0;
                else if (bc.semi)  phase_next = PH_NAME0;
                else if (bc.cr)    phase_next = PH_CR;
            end
            PH_AFTNAME:
            begin
                if (bc.ows)        phase_next = PH_AFTNAME;
                else if (bc.equal) phase_next = PH_VAL0;
                else if (bc.semi)  phase_next = PH_NAME0;
                else if (bc.cr)    phase_next = PH_CR;
            end
            PH_VAL0:
            begin
                if (bc.ows)         phase_next = PH_VAL0;
                else if (bc.dquote) phase_next = PH_QUOTED;
                else if (bc.tchar)  phase_next = PH_TOKVAL;
            end
            PH_TOKVAL:
            begin
                if (bc.tchar)     phase_next = PH_TOKVAL;
                else if (bc.ows)  phase_next = PH_EXPECT;
                else if (bc.semi) phase_next = PH_NAME0;
                else if (bc.cr)   phase_next = PH_CR;
            end
            PH_QUOTED:
            begin
                if (bc.dquote)         phase_next = PH_EXPECT;
                else if (bc.bslash)    phase_next = PH_ESCAPE;
                else if (!bc.bad_qchar) phase_next = PH_QUOTED;
            end
            PH_ESCAPE:
            begin
                if (!bc.bad_qchar) phase_next = PH_QUOTED;
            end
            PH_CR:
            begin
                if (bc.lf) phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // Status follows from the phase the byte leads to.
    always_comb
    begin
        if (phase_next == PH_ERROR)
        begin
            status_next = ST_ERR;
        end
        else if (phase_next == PH_DONE)
        begin
            status_next = ST_DONE;
        end
        else
        begin
            status_next = ST_BUSY;
        end
    end

    // Phase register, updated once per byte that moves to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EXPECT;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: rtl/http_chunk_ext_checker.sv
// Top level of the chunk-extension checker: input stage, phase core, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------
//  in      | input     | in_valid / in_stall  | data_byte, start_line
//  out     | output    | out_valid / out_stall| status
//
// Each byte passes from the input register through the phase logic into the result register.
// One byte is accepted every cycle while no output stall holds the flow; the next phase
// is computed combinationally from the phase register and the classifier.
// Reset clears the phase to line start and empties both stages.
// An output stall holds the result and reaches in_stall in the same cycle once the
// input register is full, so at most two more bytes are taken while it lasts, one per empty stage.
module http_chunk_ext_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             start_line,
    output logic             out_valid,
    input  logic             out_stall,
    output hce_pkg::status_t status
);
    import hce_pkg::*;

    logic    held_valid;
    logic [7:0] held_byte;
    logic    held_start;
    logic    advance;
    status_t status_next;
    status_t status_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // A held byte moves on when the result register is empty or being drained.
    assign advance = held_valid && (!out_valid_reg || !out_stall);

    hce_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .start_line (start_line),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_start (held_start)
    );

    hce_phase_core u_phase_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cur_byte    (held_byte),
        .cur_start   (held_start),
        .status_next (status_next)
    );

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

// File: verif/tb_http_chunk_ext_checker.sv
// Self-checking testbench for the chunk-extension checker: directed table, then random lines.
module tb_http_chunk_ext_checker;
    import hce_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1500;
    localparam int unsigned QUIET_TAIL   = 150;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PRINT_LIMIT  = 40;

    // One byte of a chunk line; typed rows carry their own expected status.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        status_t    status;
    } line_byte_t;

    // One status still owed by the block, with the byte that caused it.
    typedef struct packed {
        status_t     status;
        logic [7:0]  data;
        logic [31:0] seq;
    } owed_status_t;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_stall;
    logic    [7:0] data_byte = 8'h00;
    logic    start_line = 1'b0;
    logic    out_valid;
    logic    out_stall  = 1'b0;
    status_t status;

    line_byte_t   line_bytes [$];
    owed_status_t owed_status [$];
    logic [7:0]   token_chars [$];
    phase_t       parser_phase = PH_EXPECT;
    logic         line_start   = 1'b0;
    bit           quiet_tail   = 1'b0;
    bit           feed_done    = 1'b0;
    int unsigned  items_taken  = 0;
    int unsigned  results_seen = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count  = 0;

    // Hand-written cases: quoted value with a high byte and an escape, a byte after a
    // quoted value, token value with OWS and line end, bytes after the line end with a
    // sticky error, lone CR, stray byte, empty name and empty value.
    line_byte_t directed_rows [28] = '{
        '{CH_SEMI,   1'b1, 1'b1, ST_BUSY},
        '{8'h61,     1'b0, 1'b1, ST_BUSY},
        '{CH_EQUAL,  1'b0, 1'b1, ST_BUSY},
        '{CH_DQUOTE, 1'b0, 1'b1, ST_BUSY},
        '{8'hFF,     1'b0, 1'b1, ST_BUSY},
        '{CH_BSLASH, 1'b0, 1'b0, ST_BUSY},
        '{CH_DQUOTE, 1'b0, 1'b0, ST_BUSY},
        '{CH_TAB,    1'b0, 1'b0, ST_BUSY},
        '{CH_DQUOTE, 1'b0, 1'b0, ST_BUSY},
        '{8'h62,     1'b0, 1'b1, ST_ERR},
        '{CH_SEMI,   1'b1, 1'b1, ST_BUSY},
        '{8'h7E,     1'b0, 1'b0, ST_BUSY},
        '{CH_EQUAL,  1'b0, 1'b0, ST_BUSY},
        '{8'h21,     1'b0, 1'b0, ST_BUSY},
        '{CH_SP,     1'b0, 1'b0, ST_BUSY},
        '{CH_CR,     1'b0, 1'b0, ST_BUSY},
        '{CH_LF,     1'b0, 1'b1, ST_DONE},
        '{8'h78,     1'b0, 1'b1, ST_ERR},
        '{8'h00,     1'b0, 1'b1, ST_ERR},
        '{CH_CR,     1'b1, 1'b1, ST_BUSY},
        '{8'h7A,     1'b0, 1'b1, ST_ERR},
        '{8'h40,     1'b1, 1'b1, ST_ERR},
        '{CH_SEMI,   1'b1, 1'b1, ST_BUSY},
        '{CH_EQUAL,  1'b0, 1'b1, ST_ERR},
        '{CH_SEMI,   1'b1, 1'b1, ST_BUSY},
        '{8'h6E,     1'b0, 1'b0, ST_BUSY},
        '{CH_EQUAL,  1'b0, 1'b0, ST_BUSY},
        '{CH_DEL,    1'b0, 1'b1, ST_ERR}
    };

    http_chunk_ext_checker dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .start_line (start_line),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status)
    );

    // Clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Reset held from the start and released once.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // RFC tchar set: digits, letters and a fixed list of punctuation.
    function automatic bit is_token_char(input logic [7:0] c);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
            default: return ((c >= 8'h30) && (c <= 8'h39)) ||
                            ((c >= 8'h41) && (c <= 8'h5A)) ||
                            ((c >= 8'h61) && (c <= 8'h7A));
        endcase
    endfunction

    // Next parser phase for one byte.
    function automatic phase_t phase_after_byte(input phase_t ph, input logic [7:0] c);
        bit     blank;
        bit     tok;
        bit     bad_q;
        phase_t nxt;
        blank = (c == CH_SP) || (c == CH_TAB);
        tok   = is_token_char(c);
        bad_q = ((c < CH_SP) && (c != CH_TAB)) || (c == CH_DEL);
        case (ph)
            PH_EXPECT:  nxt = blank ? PH_EXPECT : (c == CH_SEMI) ? PH_NAME0 :
                              (c == CH_CR) ? PH_CR : PH_ERROR;
            PH_NAME0:   nxt = blank ? PH_NAME0 : tok ? PH_NAME : PH_ERROR;
            PH_NAME:    nxt = tok ? PH_NAME : blank ? PH_AFTNAME :
                              (c == CH_EQUAL) ? PH_VAL0 : (c == CH_SEMI) ? PH_NAME0 :
                              (c == CH_CR) ? PH_CR : PH_ERROR;
            PH_AFTNAME: nxt = blank ? PH_AFTNAME : (c == CH_EQUAL) ? PH_VAL0 :
                              (c == CH_SEMI) ? PH_NAME0 : (c == CH_CR) ? PH_CR : PH_ERROR;
            PH_VAL0:    nxt = blank ? PH_VAL0 : (c == CH_DQUOTE) ? PH_QUOTED :
                              tok ? PH_TOKVAL : PH_ERROR;
            PH_TOKVAL:  nxt = tok ? PH_TOKVAL : blank ? PH_EXPECT :
                              (c == CH_SEMI) ? PH_NAME0 : (c == CH_CR) ? PH_CR : PH_ERROR;
            PH_QUOTED:  nxt = (c == CH_DQUOTE) ? PH_EXPECT : (c == CH_BSLASH) ? PH_ESCAPE :
                              bad_q ? PH_ERROR : PH_QUOTED;
            PH_ESCAPE:  nxt = bad_q ? PH_ERROR : PH_QUOTED;
            PH_CR:      nxt = (c == CH_LF) ? PH_DONE : PH_ERROR;
            default:    nxt = PH_ERROR;
        endcase
        return nxt;
    endfunction

    function automatic logic [7:0] pick_token_char();
        return token_chars[$urandom_range(0, token_chars.size() - 1)];
    endfunction

    // Legal byte inside a quoted string; quote and backslash only after a backslash.
    function automatic logic [7:0] pick_quoted_char(input bit escaped);
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = CH_TAB;
            1, 2:    c = 8'($urandom_range(8'h80, 8'hFF));
            default: c = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        if (!escaped && ((c == CH_DQUOTE) || (c == CH_BSLASH)))
        begin
            c = 8'h78;
        end
        return c;
    endfunction

    // Appends one byte; the first byte after line_start is set marks a new line.
    task automatic push_byte(input logic [7:0] d);
        line_bytes.push_back('{d, line_start, 1'b0, ST_BUSY});
        line_start = 1'b0;
    endtask

    // Optional run of spaces and tabs.
    task automatic push_ows();
        repeat ($urandom_range(0, 2))
        begin
            push_byte(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
        end
    endtask

    // Reports one mismatch, printing only the first few.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Builds the stimulus, then offers every byte and records the status it must cause.
    initial
    begin : feed
        int unsigned first;
        int unsigned pick;
        int unsigned hit;
        bit          gaps_on;
        line_byte_t  cur;
        owed_status_t owed;

        for (int v = 0; v < 256; v++)
        begin
            if (is_token_char(8'(v)))
            begin
                token_chars.push_back(8'(v));
            end
        end

        foreach (directed_rows[r])
        begin
            line_bytes.push_back(directed_rows[r]);
        end

        // Mostly well-formed lines with random content, some broken, some pure noise.
        while (line_bytes.size() < $size(directed_rows) + RANDOM_BYTES)
        begin
            first = line_bytes.size();
            pick  = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    line_start = ($urandom_range(0, 3) == 0);
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                // Without a start marker the line continues from the previous state.
                line_start = (pick != 1);
                push_ows();
                repeat ($urandom_range(0, 3))
                begin
                    push_byte(CH_SEMI);
                    push_ows();
                    repeat ($urandom_range(1, 4)) push_byte(pick_token_char());
                    push_ows();
                    if ($urandom_range(0, 2) != 0)
                    begin
                        push_byte(CH_EQUAL);
                        push_ows();
                        if ($urandom_range(0, 1) == 0)
                        begin
                            repeat ($urandom_range(1, 4)) push_byte(pick_token_char());
                        end
                        else
                        begin
                            push_byte(CH_DQUOTE);
                            repeat ($urandom_range(0, 6))
                            begin
                                if ($urandom_range(0, 4) == 0)
                                begin
                                    push_byte(CH_BSLASH);
                                    push_byte(pick_quoted_char(1'b1));
                                end
                                else
                                begin
                                    push_byte(pick_quoted_char(1'b0));
                                end
                            end
                            push_byte(CH_DQUOTE);
                        end
                        push_ows();
                    end
                end
                push_byte(CH_CR);
                push_byte(CH_LF);
                // Corrupt one byte of some lines.
                if ($urandom_range(0, 5) == 0)
                begin
                    hit = $urandom_range(first, line_bytes.size() - 1);
                    line_bytes[hit].data = 8'($urandom_range(0, 255));
                end
            end
        end

        wait (rst_n === 1'b1);
        @(posedge clk);
        gaps_on = 1'b0;

        // Offer each byte and wait for its transfer.
        for (int i = 0; i < line_bytes.size(); i++)
        begin
            cur = line_bytes[i];
            if (i % 64 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (i + QUIET_TAIL >= line_bytes.size())
            begin
                quiet_tail = 1'b1;
            end
            if (gaps_on && !quiet_tail && ($urandom_range(0, 3) == 0))
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid   <= 1'b1;
            data_byte  <= cur.data;
            start_line <= cur.start;
            @(posedge clk);
            while (in_stall) @(posedge clk);

            if (cur.start)
            begin
                parser_phase = PH_EXPECT;
            end
            parser_phase = phase_after_byte(parser_phase, cur.data);
            owed.data = cur.data;
            owed.seq  = i;
            if (cur.typed)
            begin
                owed.status = cur.status;
            end
            else
            begin
                owed.status = (parser_phase == PH_ERROR) ? ST_ERR :
                              (parser_phase == PH_DONE) ? ST_DONE : ST_BUSY;
            end
            owed_status.push_back(owed);
            items_taken++;
        end
        in_valid  <= 1'b0;
        feed_done = 1'b1;
    end

    // Receiver stalls: short random bursts, one long hold-off, calm stretches.
    initial
    begin : stall_side
        bit          hold_done;
        int unsigned stall_mode;
        hold_done  = 1'b0;
        stall_mode = 1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (cycle_count % 64 == 0)
            begin
                stall_mode = $urandom_range(0, 2);
            end
            if (!hold_done && (items_taken >= HOLD_AT))
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && (stall_mode != 0) && ($urandom_range(0, 4) == 0))
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each status transfer with the oldest owed status.
    always @(posedge clk)
    begin
        owed_status_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (owed_status.size() == 0)
            begin
                report_mismatch($sformatf("status %0d with no byte owing one", status));
            end
            else
            begin
                head = owed_status.pop_front();
                if (status !== head.status)
                begin
                    report_mismatch($sformatf("byte %0d (0x%02h): status %0d, wanted %0d",
                                              head.seq, head.data, status, head.status));
                end
            end
        end
    end

    // Cycle limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // End of run: drain, let the pipeline settle, give the verdict.
    initial
    begin : verdict
        wait (feed_done);
        while (owed_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/hce_pkg.sv
rtl/hce_in_stage.sv
rtl/hce_phase_core.sv
rtl/http_chunk_ext_checker.sv
verif/tb_http_chunk_ext_checker.sv
